[rtl/hsb_pkg.sv]
`timescale 1ns / 1ps
package hsb_pkg;

	typedef enum logic [1:0] {
		CMD_H2S = 2'd0,
		CMD_S2H = 2'd1,
		CMD_B2S = 2'd2,
		CMD_S2B = 2'd3
	} cmd_t;

	localparam logic [31:0] HSB_ROUND_ADD      = 32'h0000_1000;
	localparam logic [23:0] HSB_SUB_BIAS       = 24'h7F_F000;
	localparam logic [7:0]  HSB_INF_LIMIT      = 8'd142;
	localparam logic [7:0]  HSB_NORM_LIMIT     = 8'd112;
	localparam logic [7:0]  HSB_SUB_SHIFT_BASE = 8'd125;
	localparam logic [7:0]  HSB_SHIFT_CAP      = 8'd31;
	localparam logic [7:0]  HSB_SUB_EXP_BASE   = 8'd103;
	localparam logic [7:0]  HSB_SINGLE_EXP_MAX = 8'hFF;
	localparam logic [4:0]  HSB_HALF_EXP_MAX   = 5'h1F;
	localparam logic [30:0] HSB_SINGLE_INF_MAG = 31'h7F80_0000;
	localparam logic [9:0]  HSB_QUIET_BIT      = 10'h200;
	localparam logic [3:0]  HSB_HALF_MANT_W    = 4'd10;

endpackage

[rtl/hsb_half_to_single.sv]
`timescale 1ns / 1ps
module hsb_half_to_single (
	input  logic [15:0] half_bits,
	output logic [31:0] single_bits
);
	import hsb_pkg::*;

	logic [4:0] exp_h;
	logic [9:0] mant_h;
	logic [3:0] top_pos;
	logic [3:0] norm_sh;
	logic [7:0] exp_s;
	logic [9:0] mant_s;

	assign exp_h  = half_bits[14:10];
	assign mant_h = half_bits[9:0];

	always_comb begin
		top_pos = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (mant_h[i]) begin
				top_pos = 4'(i);
			end
		end
	end

	assign norm_sh = HSB_HALF_MANT_W - top_pos;

	always_comb begin
		if (exp_h == HSB_HALF_EXP_MAX) begin
			exp_s  = HSB_SINGLE_EXP_MAX;
			mant_s = (mant_h != 10'd0) ? (mant_h | HSB_QUIET_BIT) : mant_h;
		end else if (exp_h != 5'd0) begin
			exp_s  = {3'b000, exp_h} + HSB_NORM_LIMIT;
			mant_s = mant_h;
		end else if (mant_h != 10'd0) begin
			exp_s  = HSB_SUB_EXP_BASE + {4'b0000, top_pos};
			mant_s = mant_h << norm_sh;
		end else begin
			exp_s  = 8'd0;
			mant_s = 10'd0;
		end
	end

	assign single_bits = {half_bits[15], exp_s, mant_s, 13'd0};

endmodule

[rtl/hsb_single_to_half.sv]
`timescale 1ns / 1ps
module hsb_single_to_half (
	input  logic [31:0] single_bits,
	output logic [15:0] half_bits
);
	import hsb_pkg::*;

	logic [31:0] rounded;
	logic [7:0]  exp_r;
	logic [22:0] mant_r;
	logic        is_nan;
	logic [7:0]  sh_raw;
	logic [4:0]  sh;
	logic [23:0] sub_sum;
	logic [23:0] sub_shifted;
	logic [11:0] sub_inc;
	logic [10:0] sub_mant;
	logic [4:0]  exp_norm;
	logic        sign;

	assign sign    = single_bits[31];
	assign rounded = single_bits + HSB_ROUND_ADD;
	assign exp_r   = rounded[30:23];
	assign mant_r  = rounded[22:0];
	assign is_nan  = single_bits[30:0] > HSB_SINGLE_INF_MAG;

	assign exp_norm = 5'(exp_r - HSB_NORM_LIMIT);

	assign sh_raw      = HSB_SUB_SHIFT_BASE - exp_r;
	assign sh          = (sh_raw > HSB_SHIFT_CAP) ? HSB_SHIFT_CAP[4:0] : sh_raw[4:0];
	assign sub_sum     = {1'b0, mant_r} + HSB_SUB_BIAS;
	assign sub_shifted = sub_sum >> sh;
	assign sub_inc     = {1'b0, sub_shifted[10:0]} + 12'd1;
	assign sub_mant    = sub_inc[11:1];

	always_comb begin
		if (is_nan) begin
			half_bits = {sign, HSB_HALF_EXP_MAX, single_bits[22:13] | HSB_QUIET_BIT};
		end else if (exp_r > HSB_INF_LIMIT) begin
			half_bits = {sign, HSB_HALF_EXP_MAX, 10'd0};
		end else if (exp_r > HSB_NORM_LIMIT) begin
			half_bits = {sign, exp_norm, mant_r[22:13]};
		end else begin
			half_bits = {sign, 4'd0, sub_mant};
		end
	end

endmodule

[rtl/half_single_bfloat_converter_unit.sv]
`timescale 1ns / 1ps
// Converts one 32-bit pattern per request between half, single and bfloat
// formats (cmd selects the direction); 16-bit results come back zero-extended.
// One request is taken every cycle unless in_stall is high; each result passes
// through the input register and then the result register, which bracket the
// combinational conversion logic. A stalled result holds in the result register
// while the input register still takes one more request.
module half_single_bfloat_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] operand_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_bits
);
	import hsb_pkg::*;

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [31:0] operand_s1;
	logic        valid_s2;
	logic [31:0] result_s2;
	logic        load_s1;
	logic        load_s2;
	logic [31:0] h2s_bits;
	logic [15:0] s2h_bits;
	logic [31:0] conv_bits;

	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1 || load_s2) begin
				valid_s1 <= load_s1;
			end
			if (load_s2 || !out_stall) begin
				valid_s2 <= load_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1     <= cmd;
			operand_s1 <= operand_bits;
		end
		if (load_s2) begin
			result_s2 <= conv_bits;
		end
	end

	hsb_half_to_single u_h2s (
		.half_bits   (operand_s1[15:0]),
		.single_bits (h2s_bits)
	);

	hsb_single_to_half u_s2h (
		.single_bits (operand_s1),
		.half_bits   (s2h_bits)
	);

	always_comb begin
		case (cmd_t'(cmd_s1))
			CMD_H2S: conv_bits = h2s_bits;
			CMD_S2H: conv_bits = {16'd0, s2h_bits};
			CMD_B2S: conv_bits = {operand_s1[15:0], 16'd0};
			CMD_S2B: conv_bits = {16'd0, operand_s1[31:16]};
			default: conv_bits = {16'd0, operand_s1[31:16]};
		endcase
	end

	assign out_valid   = valid_s2;
	assign result_bits = result_s2;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall))
		else $error("input stalled while result stage can advance");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request lost from input stage");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s1) |=> !out_valid)
		else $error("result repeated after delivery");

	a_half_width_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && (cmd_s1 == CMD_S2B || cmd_s1 == CMD_S2H)) |=> (result_bits[31:16] == 16'd0))
		else $error("16-bit result not zero-extended");

endmodule

[test/tb_half_single_bfloat_converter_unit.sv]
`timescale 1ns / 1ps
module tb_half_single_bfloat_converter_unit;
	import hsb_pkg::*;

	localparam int N_DIRECTED  = 25;
	localparam int N_RANDOM    = 1400;
	localparam int N_QUIET     = 200;
	localparam int IDLE_LIMIT  = 1000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		cmd_t        op;
		logic [31:0] src;
		logic [31:0] want;
		logic        typed;
	} stim_row_t;

	typedef struct packed {
		cmd_t        op;
		logic [31:0] src;
		logic [31:0] want;
	} conv_req_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd          = CMD_H2S;
	logic [31:0] operand_bits = 32'h0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [31:0] result_bits;

	conv_req_t   expected_results[$];
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	bit          quiet_tail     = 1'b0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{CMD_H2S, 32'h0000_0000, 32'h0000_0000, 1'b1},
		'{CMD_H2S, 32'h0000_8000, 32'h8000_0000, 1'b1},
		'{CMD_H2S, 32'h0000_3C00, 32'h3F80_0000, 1'b1},
		'{CMD_H2S, 32'h0000_7C00, 32'h7F80_0000, 1'b1},
		'{CMD_H2S, 32'h0000_FC00, 32'hFF80_0000, 1'b1},
		'{CMD_H2S, 32'h0000_7C01, 32'h7FC0_2000, 1'b1},
		'{CMD_H2S, 32'h0000_0001, 32'h0, 1'b0},
		'{CMD_H2S, 32'h0000_83FF, 32'h0, 1'b0},
		'{CMD_H2S, 32'hFFFF_7BFF, 32'h0, 1'b0},
		'{CMD_S2H, 32'h0000_0000, 32'h0000_0000, 1'b1},
		'{CMD_S2H, 32'h8000_0000, 32'h0000_8000, 1'b1},
		'{CMD_S2H, 32'h3F80_0000, 32'h0000_3C00, 1'b1},
		'{CMD_S2H, 32'h7F80_0000, 32'h0000_7C00, 1'b1},
		'{CMD_S2H, 32'hFF80_0000, 32'h0000_FC00, 1'b1},
		'{CMD_S2H, 32'h7FC0_0000, 32'h0000_7E00, 1'b1},
		'{CMD_S2H, 32'hFF80_0001, 32'h0000_FE00, 1'b1},
		'{CMD_S2H, 32'h477F_E000, 32'h0, 1'b0},
		'{CMD_S2H, 32'h477F_F000, 32'h0, 1'b0},
		'{CMD_S2H, 32'h387F_F000, 32'h0, 1'b0},
		'{CMD_S2H, 32'h3300_0000, 32'h0, 1'b0},
		'{CMD_S2H, 32'h0000_0001, 32'h0, 1'b0},
		'{CMD_S2B, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1},
		'{CMD_S2B, 32'h1234_5678, 32'h0000_1234, 1'b1},
		'{CMD_B2S, 32'hABCD_1234, 32'h1234_0000, 1'b1},
		'{CMD_B2S, 32'h0000_FFFF, 32'hFFFF_0000, 1'b1}
	};

	half_single_bfloat_converter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.operand_bits (operand_bits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_bits  (result_bits)
	);

	function automatic logic [31:0] widen_half(logic [15:0] h);
		logic [7:0] ex;
		logic [9:0] man;
		int         top;
		man = h[9:0];
		if (h[14:10] == HSB_HALF_EXP_MAX) begin
			ex = HSB_SINGLE_EXP_MAX;
			if (man != 10'h0)
				man = man | HSB_QUIET_BIT;
		end else if (h[14:10] != 5'h0) begin
			ex = {3'b0, h[14:10]} + HSB_NORM_LIMIT;
		end else if (man != 10'h0) begin
			top = 0;
			for (int i = 0; i < 10; i++)
				if (man[i])
					top = i;
			ex = HSB_SUB_EXP_BASE + 8'(top);
			man = man << (10 - top);
		end else begin
			ex = 8'h0;
		end
		return {h[15], ex, man, 13'b0};
	endfunction

	function automatic logic [15:0] narrow_single(logic [31:0] w);
		logic [31:0] rnd;
		logic [31:0] frac;
		logic [7:0]  ex;
		logic [7:0]  hex;
		int          shift;
		rnd = w + HSB_ROUND_ADD;
		ex  = rnd[30:23];
		if (w[30:0] > HSB_SINGLE_INF_MAG)
			return {w[31], HSB_HALF_EXP_MAX, 1'b1, w[21:13]};
		if (ex > HSB_INF_LIMIT)
			return {w[31], HSB_HALF_EXP_MAX, 10'h0};
		if (ex > HSB_NORM_LIMIT) begin
			hex = ex - HSB_NORM_LIMIT;
			return {w[31], hex[4:0], rnd[22:13]};
		end
		shift = int'(HSB_SUB_SHIFT_BASE) - int'(ex);
		if (shift > int'(HSB_SHIFT_CAP))
			shift = int'(HSB_SHIFT_CAP);
		frac = ({9'b0, rnd[22:0]} + {8'b0, HSB_SUB_BIAS}) >> shift;
		frac = (frac + 32'd1) >> 1;
		return {w[31], 15'b0} | frac[15:0];
	endfunction

	function automatic logic [31:0] convert_pattern(cmd_t op, logic [31:0] x);
		case (op)
			CMD_H2S: return widen_half(x[15:0]);
			CMD_S2H: return {16'h0, narrow_single(x)};
			CMD_B2S: return {x[15:0], 16'h0};
			default: return {16'h0, x[31:16]};
		endcase
	endfunction

	function automatic logic [31:0] pick_operand(cmd_t op);
		logic [31:0] v;
		v = $urandom();
		if (op == CMD_S2H) begin
			case ($urandom_range(0, 7))
				0, 1, 2: v[30:23] = 8'($urandom_range(100, 146));
				3: v[30:23] = 8'($urandom_range(60, 112));
				4: v[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
				5: begin
					v[30:23] = 8'($urandom_range(110, 144));
					v[12:0] = ($urandom_range(0, 1) != 0) ? 13'h1000 : 13'h0FFF;
				end
				6: begin
					v[30:23] = 8'($urandom_range(111, 143));
					v[22:13] = 10'h3FF;
				end
				default: ;
			endcase
		end else if (op == CMD_H2S) begin
			case ($urandom_range(0, 3))
				0: v[14:10] = 5'h00;
				1: v[14:10] = HSB_HALF_EXP_MAX;
				default: ;
			endcase
		end
		return v;
	endfunction

	task automatic note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic send_request(cmd_t op, logic [31:0] src, logic [31:0] want, bit typed);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= op;
		operand_bits <= src;
		do @(posedge clk); while (in_stall);
		expected_results.push_back('{op, src, typed ? want : convert_pattern(op, src)});
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cmd_t op;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].src,
				directed_rows[i].want, directed_rows[i].typed);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - N_QUIET)
				quiet_tail = 1'b1;
			op = cmd_t'($urandom_range(0, 3));
			send_request(op, pick_operand(op), 32'h0, 1'b0);
		end
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		while (!quiet_tail) begin
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		out_stall <= 1'b0;
	end

	always @(posedge clk) begin : check_results
		conv_req_t head;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				note_failure($sformatf("unexpected result %h", result_bits));
			end else begin
				head = expected_results.pop_front();
				if (result_bits !== head.want)
					note_failure($sformatf("cmd %s operand %h: expected %h, got %h",
						head.op.name(), head.src, head.want, result_bits));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

[sim.f]
rtl/hsb_pkg.sv
rtl/hsb_half_to_single.sv
rtl/hsb_single_to_half.sv
rtl/half_single_bfloat_converter_unit.sv
test/tb_half_single_bfloat_converter_unit.sv
